// File: rtl/core/bfea_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box filter.
// Depends on nothing; imported by the box filter top level.
package bfea_pkg;

   localparam int PIX_W        = 8;
   localparam int COL_SUM_W    = 10;
   localparam int WIN_SUM_W    = 12;
   localparam int CNT_W        = 4;
   localparam int RECIP_W      = 17;
   localparam int RECIP_SHIFT  = 16;
   localparam int PROD_W       = WIN_SUM_W + RECIP_W;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W        = 12;
   localparam int CSR_DATA_W   = 13;
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_AW      = 3;
   localparam int FIFO_CW      = 4;
   localparam int OCC_W        = 5;

   // Tallest frame accepted; larger heights act as this
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;
   // Reset frame geometry: height as last index, width as a count
   localparam logic [ROW_W-1:0]        H_LAST_RST   = 12'd1023;
   localparam int                      W_RST        = 1024;

   // Pipeline operation codes
   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_DRAIN = 2'd1;
   localparam logic [1:0] OP_PRIME = 2'd2;

   // Input command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Configuration register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // One queued result: window sum, divisor and flags
   typedef struct packed {
      logic [WIN_SUM_W-1:0] sum;
      logic [CNT_W-1:0]     cnt;
      logic                 last;
      logic                 fend;
   } result_type;

   // ceil(2^16 / divisor); exact floor division for sums up to 9 * 255
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] m;
      unique case (cnt)
         4'd1:    m = 17'd65536;
         4'd2:    m = 17'd32768;
         4'd3:    m = 17'd21846;
         4'd4:    m = 17'd16384;
         4'd6:    m = 17'd10923;
         4'd9:    m = 17'd7282;
         default: m = 17'd0;
      endcase
      return m;
   endfunction

endpackage

// File: rtl/core/box_filter_3x3_edge_average_unit.sv
// Top level of the streaming 3x3 box filter with edge-aware averaging.
// Depends on bfea_pkg (types, operation codes, reciprocal table).

// Gray pixels enter in raster order, one transaction per clock unless stalled;
// each result is the floor of the mean of the 3x3 neighbourhood, neighbours
// outside the frame left out. A pixel's results reach the output through a
// registered read of the two line memories (one read and one write port each),
// then the column and window sums, then an eight-entry result queue whose head
// is divided by a reciprocal multiply. After the last pixel of a frame the
// input stalls while column zero of the final rows is read to prime the
// window; drain ticks then go at one per cycle unless the input stalls. The
// input also stalls when the result queue cannot take two more results.
// Writing either geometry register restarts the frame; write it only while the
// block is idle.
module box_filter_3x3_edge_average_unit
   import bfea_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [PIX_W-1:0]      req_pixel_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_smoothed_value,
   output logic                  rsp_last_in_run,
   output logic                  rsp_frame_end
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int CW  = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
   localparam logic [CW-1:0] MAX_W_C    = CW'(MAX_WIDTH);
   localparam logic [AW-1:0] W_LAST_MAX = AW'(MAX_WIDTH - 1);
   localparam logic [AW-1:0] W_LAST_RST = AW'(((MAX_WIDTH < W_RST) ? MAX_WIDTH : W_RST) - 1);

   typedef struct packed {
      logic [1:0]       op;
      logic [AW-1:0]    addr;
      logic [PIX_W-1:0] pix;
      logic             r_ge1;
      logic             r_ge2;
      logic             two_rows;
      logic             have_read;
      logic             clear;
      logic             emit_a;
      logic             emit_b;
      logic             last_a;
      logic             fend_a;
      logic [CNT_W-1:0] cnt_a;
      logic [CNT_W-1:0] cnt_b;
   } stage_type;

   // Geometry and position state
   logic [AW-1:0]    w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;
   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [AW-1:0]    drain_ff, drain_in;
   logic             draining_ff, draining_in;
   logic             prime_ff, prime_in;

   // Read stage
   stage_type        s1_ff, s1_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;

   // Line memories and write forwarding
   logic [PIX_W-1:0] upper_line_ff  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_line_ff [MAX_WIDTH];
   logic [PIX_W-1:0] up_rd_ff, mid_rd_ff;
   logic             byp_ff, byp_in;
   logic [PIX_W-1:0] byp_up_ff, byp_up_in;
   logic [PIX_W-1:0] byp_mid_ff, byp_mid_in;
   logic             wr_en;
   logic [PIX_W-1:0] up_v, mid_v;

   // Column sums of the window
   logic [COL_SUM_W-1:0] win_prev_ff, win_prev_in;
   logic [COL_SUM_W-1:0] win_cur_ff, win_cur_in;
   logic [COL_SUM_W-1:0] cs, n0, n1;
   logic [WIN_SUM_W-1:0] sum_a, sum_b;
   logic                 push_a, push_b;
   result_type           res_a, res_b;

   // Result queue
   result_type           fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   head_ff, head_in;
   logic [FIFO_AW-1:0]   tail_ff, tail_in;
   logic [FIFO_AW-1:0]   tail_b;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic [OCC_W-1:0]     occupancy;
   logic                 pop;
   result_type           head_entry;
   logic [PROD_W-1:0]    prod;

   // Decoded configuration
   logic [CW-1:0]           wv;
   logic [AW-1:0]           w_new;
   logic [HEIGHT_REG_W-1:0] hv, hv_m1;
   logic [ROW_W-1:0]        h_new;

   // Read-stage helpers
   logic             accept;
   logic             c_ge1, c_ge2, last_col, r_ge1, r_ge2;
   logic             at_end, two_rows;
   logic [1:0]       ncols;

   // Stall while priming the window or while the queue may overflow
   assign occupancy = OCC_W'(count_ff) + (s1_valid_ff ? OCC_W'(2) : OCC_W'(0));
   assign req_stall = prime_ff || (occupancy > OCC_W'(FIFO_DEPTH - 2));
   assign accept    = req_valid && !req_stall;

   // Clamp written geometry into last-index form
   always_comb begin
      wv    = CW'(csr_wr_data[WIDTH_REG_W-1:0]);
      hv    = csr_wr_data[HEIGHT_REG_W-1:0];
      hv_m1 = hv - 13'd1;
      if (wv == '0) begin
         w_new = '0;
      end else if (wv > MAX_W_C) begin
         w_new = W_LAST_MAX;
      end else begin
         w_new = AW'(wv - CW'(1));
      end
      if (hv == '0) begin
         h_new = '0;
      end else if (hv > HEIGHT_LIMIT) begin
         h_new = 12'd4095;
      end else begin
         h_new = hv_m1[ROW_W-1:0];
      end
   end

   // Decode the transaction, issue the line read and advance positions
   always_comb begin
      w_last_in   = w_last_ff;
      h_last_in   = h_last_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      draining_in = draining_ff;
      prime_in    = prime_ff;
      s1_in       = '0;
      s1_valid_in = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = col_ff;

      c_ge1    = (col_ff != '0);
      c_ge2    = (col_ff > AW'(1));
      last_col = (col_ff == w_last_ff);
      r_ge1    = (row_ff != '0);
      r_ge2    = (row_ff > 12'd1);
      at_end   = (drain_ff == w_last_ff);
      two_rows = (h_last_ff != '0);
      ncols    = 2'd1 + {1'b0, (drain_ff != '0)} + {1'b0, !at_end};

      if (prime_ff) begin
         // Load column zero of the final rows into the window
         s1_valid_in        = 1'b1;
         s1_in.op           = OP_PRIME;
         s1_in.addr         = '0;
         s1_in.two_rows     = two_rows;
         s1_in.have_read    = 1'b1;
         s1_in.clear        = 1'b1;
         rd_en              = 1'b1;
         rd_addr            = '0;
         prime_in           = 1'b0;
      end else if (accept && req_cmd == CMD_PIXEL && !draining_ff) begin
         s1_valid_in     = 1'b1;
         s1_in.op        = OP_PIXEL;
         s1_in.addr      = col_ff;
         s1_in.pix       = req_pixel_value;
         s1_in.r_ge1     = r_ge1;
         s1_in.r_ge2     = r_ge2;
         s1_in.have_read = 1'b1;
         s1_in.clear     = !c_ge1;
         s1_in.emit_a    = r_ge1 && c_ge1;
         s1_in.emit_b    = r_ge1 && last_col;
         s1_in.last_a    = !last_col;
         s1_in.cnt_a     = c_ge2 ? (r_ge2 ? 4'd9 : 4'd6) : (r_ge2 ? 4'd6 : 4'd4);
         s1_in.cnt_b     = c_ge1 ? (r_ge2 ? 4'd6 : 4'd4) : (r_ge2 ? 4'd3 : 4'd2);
         rd_en           = 1'b1;
         rd_addr         = col_ff;
         if (last_col) begin
            col_in = '0;
            if (row_ff == h_last_ff) begin
               row_in      = '0;
               drain_in    = '0;
               draining_in = 1'b1;
               prime_in    = 1'b1;
            end else begin
               row_in = row_ff + 12'd1;
            end
         end else begin
            col_in = col_ff + AW'(1);
         end
      end else if (accept && req_cmd == CMD_DRAIN && draining_ff) begin
         s1_valid_in     = 1'b1;
         s1_in.op        = OP_DRAIN;
         s1_in.addr      = drain_ff + AW'(1);
         s1_in.two_rows  = two_rows;
         s1_in.have_read = !at_end;
         s1_in.emit_a    = 1'b1;
         s1_in.last_a    = 1'b1;
         s1_in.fend_a    = at_end;
         s1_in.cnt_a     = two_rows ? {1'b0, ncols, 1'b0} : {2'b00, ncols};
         rd_en           = !at_end;
         rd_addr         = drain_ff + AW'(1);
         if (at_end) begin
            col_in      = '0;
            row_in      = '0;
            drain_in    = '0;
            draining_in = 1'b0;
         end else begin
            drain_in = drain_ff + AW'(1);
         end
      end

      // Any geometry write restarts the frame
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  w_last_in = w_new;
            CSR_FRAME_HEIGHT: h_last_in = h_new;
            default:          w_last_in = w_last_ff;
         endcase
         col_in      = '0;
         row_in      = '0;
         drain_in    = '0;
         draining_in = 1'b0;
         prime_in    = 1'b0;
      end
   end

   // Forward a write that lands on the entry being read
   assign wr_en      = s1_valid_ff && (s1_ff.op == OP_PIXEL);
   assign byp_in     = rd_en && wr_en && (rd_addr == s1_ff.addr);
   assign byp_up_in  = mid_v;
   assign byp_mid_in = s1_ff.pix;
   assign up_v       = byp_ff ? byp_up_ff : up_rd_ff;
   assign mid_v      = byp_ff ? byp_mid_ff : mid_rd_ff;

   // Line memories: shift the column down one row, read for the next transaction
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_line_ff[s1_ff.addr]  <= mid_v;
         middle_line_ff[s1_ff.addr] <= s1_ff.pix;
      end
      if (rd_en) begin
         up_rd_ff  <= upper_line_ff[rd_addr];
         mid_rd_ff <= middle_line_ff[rd_addr];
      end
   end

   // Column sum, window shift and results
   always_comb begin
      cs = '0;
      unique case (s1_ff.op)
         OP_PIXEL: begin
            cs = COL_SUM_W'(s1_ff.pix)
               + (s1_ff.r_ge1 ? COL_SUM_W'(mid_v) : '0)
               + (s1_ff.r_ge2 ? COL_SUM_W'(up_v) : '0);
         end
         OP_DRAIN, OP_PRIME: begin
            if (s1_ff.have_read) begin
               cs = COL_SUM_W'(mid_v) + (s1_ff.two_rows ? COL_SUM_W'(up_v) : '0);
            end
         end
         default: cs = '0;
      endcase

      n0 = s1_ff.clear ? '0 : win_prev_ff;
      n1 = s1_ff.clear ? '0 : win_cur_ff;
      win_prev_in = win_prev_ff;
      win_cur_in  = win_cur_ff;
      if (s1_valid_ff) begin
         win_prev_in = n1;
         win_cur_in  = cs;
      end

      sum_a = WIN_SUM_W'(n0) + WIN_SUM_W'(n1) + WIN_SUM_W'(cs);
      sum_b = WIN_SUM_W'(n1) + WIN_SUM_W'(cs);

      push_a     = s1_valid_ff && s1_ff.emit_a;
      push_b     = s1_valid_ff && s1_ff.emit_b;
      res_a.sum  = sum_a;
      res_a.cnt  = s1_ff.cnt_a;
      res_a.last = s1_ff.last_a;
      res_a.fend = s1_ff.fend_a;
      res_b.sum  = sum_b;
      res_b.cnt  = s1_ff.cnt_b;
      res_b.last = 1'b1;
      res_b.fend = 1'b0;
   end

   // Queue pointers
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign tail_b    = push_a ? tail_ff + FIFO_AW'(1) : tail_ff;
   assign tail_in   = tail_ff + FIFO_AW'(push_a) + FIFO_AW'(push_b);
   assign head_in   = head_ff + FIFO_AW'(pop);
   assign count_in  = count_ff + FIFO_CW'(push_a) + FIFO_CW'(push_b) - FIFO_CW'(pop);

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_a) begin
         fifo_ff[tail_ff] <= res_a;
      end
      if (push_b) begin
         fifo_ff[tail_b] <= res_b;
      end
   end

   // Divide the head result by reciprocal multiply
   assign head_entry         = fifo_ff[head_ff];
   assign prod               = PROD_W'(head_entry.sum) * PROD_W'(recip(head_entry.cnt));
   assign rsp_smoothed_value = prod[RECIP_SHIFT + PIX_W - 1:RECIP_SHIFT];
   assign rsp_last_in_run    = head_entry.last;
   assign rsp_frame_end      = head_entry.fend;

   // Hold the read-stage payload and forwarded data
   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      byp_up_ff  <= byp_up_in;
      byp_mid_ff <= byp_mid_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff   <= W_LAST_RST;
         h_last_ff   <= H_LAST_RST;
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         draining_ff <= 1'b0;
         prime_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
         win_prev_ff <= '0;
         win_cur_ff  <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         w_last_ff   <= w_last_in;
         h_last_ff   <= h_last_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         draining_ff <= draining_in;
         prime_ff    <= prime_in;
         s1_valid_ff <= s1_valid_in;
         byp_ff      <= byp_in;
         win_prev_ff <= win_prev_in;
         win_cur_ff  <= win_cur_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

endmodule
